// ===== hdl/teq_pkg.sv =====
// ----------------------------------------------------------------------------
// teq_pkg
// shared constants, command codes and controller/datapath bundles for the
// timed event queue
// ----------------------------------------------------------------------------
`default_nettype none

package teq_pkg;

    // default sizing
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_WIDTH_DEF  = 32;

    // most due entries emitted by one advance
    localparam int MAX_RESULTS = 16;

    // stream field widths
    localparam int MODE_W     = 2;
    localparam int IN_TIME_W  = 32;
    localparam int ID_W       = 16;
    localparam int OUT_TIME_W = 32;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 48;

    // command modes
    localparam logic [MODE_W-1:0] MODE_ADD     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;      // latch the input word
        logic insert;    // sorted insert of the latched entry
        logic remove;    // drop the first entry matching the latched time
        logic advance;   // move current time forward, saturating
        logic pop;       // move head entry to the output register
        logic last;      // last flag for the popped entry
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic match_any; // some entry holds the latched time
        logic head_due;  // entry 0 is due
        logic next_due;  // entry 1 is due
        logic out_free;  // output register can take a word
    } t_dp_status;

endpackage

`default_nettype wire

// ===== hdl/teq_datapath.sv =====
// ----------------------------------------------------------------------------
// teq_datapath
// sorted slot array with per-slot comparators, current time register and
// output register
// ----------------------------------------------------------------------------
`default_nettype none

module teq_datapath #(
    parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_WIDTH  = teq_pkg::TIME_WIDTH_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire  teq_pkg::t_dp_cmd               i_cmd,
    output teq_pkg::t_dp_status                  o_status,
    input  wire  [teq_pkg::IN_TIME_W-1:0]        i_time,
    input  wire  [teq_pkg::ID_W-1:0]             i_event_id,
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic [teq_pkg::ID_W-1:0]             o_due_id,
    output logic [teq_pkg::OUT_TIME_W-1:0]       o_due_time,
    output logic                                 o_last
);
    import teq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [TIME_WIDTH-1:0] r_time [QUEUE_DEPTH];
    logic [ID_W-1:0]       r_id   [QUEUE_DEPTH];
    logic [CW-1:0]         r_cnt;
    logic [TIME_WIDTH-1:0] r_cur;
    logic [TIME_WIDTH-1:0] r_t;
    logic [ID_W-1:0]       r_eid;
    logic                  r_out_valid;
    logic [ID_W-1:0]       r_out_id;
    logic [OUT_TIME_W-1:0] r_out_time;
    logic                  r_out_last;

    logic [QUEUE_DEPTH-1:0] w_valid;
    logic [QUEUE_DEPTH-1:0] w_le;
    logic [QUEUE_DEPTH-1:0] w_eq;
    logic [QUEUE_DEPTH-1:0] w_ge;
    logic                   w_ins_ok;
    logic [TIME_WIDTH:0]    w_sum;
    logic [TIME_WIDTH+IN_TIME_W-1:0] w_in_ext;
    logic [TIME_WIDTH+OUT_TIME_W-1:0] w_out_ext;

    // input time taken modulo the time width, head time cut to the field
    assign w_in_ext  = {{TIME_WIDTH{1'b0}}, i_time};
    assign w_out_ext = {{OUT_TIME_W{1'b0}}, r_time[0]};

    // per-slot compares against the latched time
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_valid[i] = CW'(i) < r_cnt;
            w_le[i]    = w_valid[i] && (r_time[i] <= r_t);
            w_eq[i]    = w_valid[i] && (r_time[i] == r_t);
            w_ge[i]    = r_time[i] >= r_t;
        end
    end

    assign w_ins_ok = (r_t >= r_cur) && (r_cnt != CW'(QUEUE_DEPTH));
    assign w_sum    = {1'b0, r_cur} + {1'b0, r_t};

    // status toward the controller
    always_comb begin
        o_status.match_any = |w_eq;
        o_status.head_due  = w_valid[0] && (r_time[0] <= r_cur);
        o_status.next_due  = w_valid[1] && (r_time[1] <= r_cur);
        o_status.out_free  = !r_out_valid || i_ready;
    end

    // latched command word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_t   <= w_in_ext[TIME_WIDTH-1:0];
            r_eid <= i_event_id;
        end
    end

    // slot array: insert shifts up, remove and pop shift down
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i_cmd.insert && w_ins_ok && !w_le[i]) begin
                if (i == 0 || w_le[(i == 0) ? 0 : i-1]) begin
                    r_time[i] <= r_t;
                    r_id[i]   <= r_eid;
                end else begin
                    r_time[i] <= r_time[(i == 0) ? 0 : i-1];
                    r_id[i]   <= r_id[(i == 0) ? 0 : i-1];
                end
            end else if (((i_cmd.remove && w_ge[i]) || i_cmd.pop)
                         && (i < QUEUE_DEPTH-1)) begin
                r_time[i] <= r_time[(i < QUEUE_DEPTH-1) ? i+1 : i];
                r_id[i]   <= r_id[(i < QUEUE_DEPTH-1) ? i+1 : i];
            end
        end
    end

    // fill count and current time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_cur <= '0;
        end else begin
            if (i_cmd.insert && w_ins_ok) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.remove || i_cmd.pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
            if (i_cmd.advance) begin
                r_cur <= w_sum[TIME_WIDTH] ? '1 : w_sum[TIME_WIDTH-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_out_id   <= r_id[0];
            r_out_time <= w_out_ext[OUT_TIME_W-1:0];
            r_out_last <= i_cmd.last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_due_id   = r_out_id;
    assign o_due_time = r_out_time;
    assign o_last     = r_out_last;

endmodule

`default_nettype wire

// ===== hdl/teq_ctrl.sv =====
// ----------------------------------------------------------------------------
// teq_ctrl
// command sequencer: accepts words, steps remove and advance runs
// ----------------------------------------------------------------------------
`default_nettype none

module teq_ctrl (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    output logic                           o_ready,
    input  wire  [teq_pkg::MODE_W-1:0]     i_mode,
    input  wire  teq_pkg::t_dp_status      i_status,
    output teq_pkg::t_dp_cmd               o_cmd
);
    import teq_pkg::*;

    localparam int RW = $clog2(MAX_RESULTS + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ADD    = 3'd1;
    localparam logic [2:0] S_REMOVE = 3'd2;
    localparam logic [2:0] S_SUM    = 3'd3;
    localparam logic [2:0] S_POP    = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [RW-1:0] r_emit,  n_emit;
    logic          w_cap;

    assign o_ready = (r_state == S_IDLE);
    assign w_cap   = (r_emit == RW'(MAX_RESULTS));

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_emit  = r_emit;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_mode)
                        MODE_ADD:     n_state = S_ADD;
                        MODE_REMOVE:  n_state = S_REMOVE;
                        MODE_ADVANCE: n_state = S_SUM;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD: begin
                o_cmd.insert = 1'b1;
                n_state      = S_IDLE;
            end
            S_REMOVE: begin
                if (i_status.match_any) begin
                    o_cmd.remove = 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SUM: begin
                o_cmd.advance = 1'b1;
                n_emit        = '0;
                n_state       = S_POP;
            end
            S_POP: begin
                if (!i_status.head_due || w_cap) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.pop  = 1'b1;
                    o_cmd.last = !i_status.next_due
                                 || (r_emit == RW'(MAX_RESULTS - 1));
                    n_emit     = r_emit + RW'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_emit  <= '0;
        end else begin
            r_state <= n_state;
            r_emit  <= n_emit;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/timed_event_queue_unit.sv =====
// ----------------------------------------------------------------------------
// timed_event_queue_unit
// time-sorted event queue with add, remove-by-time and advance commands
// ----------------------------------------------------------------------------
// Commands arrive on the s_axis channel, one word each. Mode add inserts an
// (time, id) entry in time order, equal times in arrival order; entries in
// the past or arriving when the queue is full are dropped. Mode remove drops
// every entry at the given time. Mode advance adds the amount to the current
// time (saturating) and emits the due entries on m_axis, earliest first,
// at most MAX_RESULTS per advance, with tlast on the final one.
// Add loads the word and then inserts it; remove drops one matching entry
// per step until none is left; advance updates the current time in the SUM
// state, then pops due entries into the output register in the POP state,
// which waits while the output register is full and m_axis is not ready.
// The sorted slot array shifts one position per remove or pop, so removed
// and emitted entries are handled one at a time. A new word is taken only
// once the previous command has finished; the output register still
// holding a word does not block that.
// Reset empties the queue and clears the current time to 0. When m_axis
// stalls, the advance run waits with the next due entry still queued.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_event_queue_unit #(
    parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_WIDTH  = teq_pkg::TIME_WIDTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // mode[1:0], time_value[33:2], event_id[49:34], zero pad
    input  wire  [teq_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // due_id[15:0], due_time[47:16]
    output logic [teq_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic                             m_axis_tlast
);
    import teq_pkg::*;

    t_dp_cmd             w_cmd;
    t_dp_status          w_status;
    logic [ID_W-1:0]       w_due_id;
    logic [OUT_TIME_W-1:0] w_due_time;

    // sequencer
    teq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_mode   (s_axis_tdata[MODE_W-1:0]),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // slot array and output register
    teq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_time     (s_axis_tdata[MODE_W +: IN_TIME_W]),
        .i_event_id (s_axis_tdata[MODE_W + IN_TIME_W +: ID_W]),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_due_id   (w_due_id),
        .o_due_time (w_due_time),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {w_due_time, w_due_id};

endmodule

`default_nettype wire

// ===== tb/timed_event_queue_unit_test.sv =====
// ----------------------------------------------------------------------------
// timed_event_queue_unit_test
// self-checking bench for the time-sorted event queue
// ----------------------------------------------------------------------------
// A short directed table walks the corner cases first: an empty advance,
// the unused mode, time and id extremes, equal-time ordering, adds in the
// past, adds into a full queue and remove with and without a match. A
// random part follows, mostly adds close to the current time mixed with
// advances, removes of queued times and some noise. Every accepted command
// word runs through a local queue model, and each due word from the block
// is compared with the oldest predicted one. Saturation of the current
// time comes last, since the time can never move back after it. Both
// stream sides idle at random in several phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module timed_event_queue_unit_test;
    import teq_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int          DEPTH        = QUEUE_DEPTH_DEF;
    localparam int          RANDOM_WORDS = 300;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 2 * MAX_RESULTS + 16;
    localparam logic [31:0] TIME_MAX     = '1;

    // one due word as seen on m_axis
    typedef struct packed {
        logic [ID_W-1:0]       id;
        logic [OUT_TIME_W-1:0] due_time;
        logic                  last;
    } due_word_t;

    // one directed command, with an optional typed-in result
    typedef struct {
        logic [MODE_W-1:0]    mode;
        logic [IN_TIME_W-1:0] tval;
        logic [ID_W-1:0]      id;
        bit                   typed;
        bit                   has_word;
        due_word_t            word;
    } cmd_row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;

    // queue model state
    logic [IN_TIME_W-1:0] sched_time [DEPTH];
    logic [ID_W-1:0]      sched_id   [DEPTH];
    int                   sched_count = 0;
    logic [IN_TIME_W-1:0] clock_now   = '0;

    due_word_t fresh_q[$];   // words from the command just modeled
    due_word_t due_q[$];     // words still owed by the block

    int err_count     = 0;
    int cycle_count   = 0;
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;

    timed_event_queue_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // cycle watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timed_event_queue_unit: mismatch");
            $finish;
        end
    end

    // sorted insert, remove by time, advance with due-word emission
    task automatic model_command(input logic [MODE_W-1:0] mode,
                                 input logic [IN_TIME_W-1:0] tval,
                                 input logic [ID_W-1:0] id);
        int          pos;
        int          i;
        int          w;
        int          n;
        logic [32:0] sum;
        fresh_q.delete();
        case (mode)
            MODE_ADD: begin
                if (tval >= clock_now && sched_count < DEPTH) begin
                    pos = 0;
                    while (pos < sched_count && sched_time[pos] <= tval)
                        pos++;
                    for (i = sched_count; i > pos; i--) begin
                        sched_time[i] = sched_time[i-1];
                        sched_id[i]   = sched_id[i-1];
                    end
                    sched_time[pos] = tval;
                    sched_id[pos]   = id;
                    sched_count++;
                end
            end
            MODE_REMOVE: begin
                w = 0;
                for (i = 0; i < sched_count; i++) begin
                    if (sched_time[i] != tval) begin
                        sched_time[w] = sched_time[i];
                        sched_id[w]   = sched_id[i];
                        w++;
                    end
                end
                sched_count = w;
            end
            MODE_ADVANCE: begin
                // saturate on carry out
                sum       = {1'b0, clock_now} + {1'b0, tval};
                clock_now = sum[32] ? TIME_MAX : sum[31:0];
                n = 0;
                while (n < sched_count && n < MAX_RESULTS && sched_time[n] <= clock_now)
                    n++;
                for (i = 0; i < n; i++)
                    fresh_q.insert(fresh_q.size(),
                                   due_word_t'{sched_id[i], sched_time[i], (i == n - 1)});
                for (i = n; i < sched_count; i++) begin
                    sched_time[i-n] = sched_time[i];
                    sched_id[i-n]   = sched_id[i];
                end
                sched_count -= n;
            end
            default: ;
        endcase
    endtask

    // drive one command word, starting and ending at a falling edge
    task automatic send_command(input logic [MODE_W-1:0] mode,
                                input logic [IN_TIME_W-1:0] tval,
                                input logic [ID_W-1:0] id,
                                input bit typed,
                                input bit has_word,
                                input due_word_t word);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, id, tval, mode};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        model_command(mode, tval, id);
        if (typed) begin
            if (has_word)
                due_q.insert(due_q.size(), word);
        end else begin
            foreach (fresh_q[i])
                due_q.insert(due_q.size(), fresh_q[i]);
        end
        @(negedge i_clk);
    endtask

    function automatic cmd_row_t row(input logic [MODE_W-1:0] mode,
                                     input logic [IN_TIME_W-1:0] tval,
                                     input logic [ID_W-1:0] id,
                                     input bit typed = 1'b0,
                                     input bit has_word = 1'b0,
                                     input due_word_t word = '0);
        cmd_row_t r;
        r.mode     = mode;
        r.tval     = tval;
        r.id       = id;
        r.typed    = typed;
        r.has_word = has_word;
        r.word     = word;
        return r;
    endfunction

    function automatic void set_phase(input int phase);
        case (phase)
            0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1:       begin src_idle_pct = 57; snk_stall_pct = 0;  end
            2:       begin src_idle_pct = 0;  snk_stall_pct = 57; end
            default: begin src_idle_pct = 20; snk_stall_pct = 20; end
        endcase
    endfunction

    // receiver stalls
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);

    // compare each accepted due word with the oldest prediction
    always @(posedge i_clk) begin : check_out
        due_word_t got;
        due_word_t want;
        got = '{m_axis_tdata[15:0], m_axis_tdata[47:16], m_axis_tlast};
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_q.size() == 0) begin
                if (err_count < 10)
                    $display("unexpected word: id %h time %h last %b",
                             got.id, got.due_time, got.last);
                err_count++;
            end else begin
                want = due_q.pop_front();
                if (got !== want) begin
                    if (err_count < 10)
                        $display({"due word: expected id %h time %h last %b, ",
                                  "got id %h time %h last %b"},
                                 want.id, want.due_time, want.last,
                                 got.id, got.due_time, got.last);
                    err_count++;
                end
            end
        end
    end

    // stimulus and verdict
    initial begin
        cmd_row_t          plan[$];
        int                k;
        int                pick;
        logic [MODE_W-1:0] m;
        logic [31:0]       t;
        logic [15:0]       id;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;

        // empty advance, unused mode, extremes, past add, remove cases
        plan.insert(plan.size(), row(MODE_ADVANCE, 32'd0, 16'h0000, 1'b1));
        plan.insert(plan.size(), row(MODE_UNUSED, TIME_MAX, 16'hFFFF, 1'b1));
        plan.insert(plan.size(), row(MODE_ADD, 32'd0, 16'hFFFF));
        plan.insert(plan.size(), row(MODE_ADVANCE, 32'd0, 16'h0000, 1'b1, 1'b1,
                                     '{16'hFFFF, 32'd0, 1'b1}));
        plan.insert(plan.size(), row(MODE_ADD, TIME_MAX, 16'h0000));
        plan.insert(plan.size(), row(MODE_REMOVE, TIME_MAX, 16'h0000, 1'b1));
        plan.insert(plan.size(), row(MODE_REMOVE, TIME_MAX, 16'h0000, 1'b1));
        plan.insert(plan.size(), row(MODE_ADVANCE, 32'd10, 16'h0000, 1'b1));
        plan.insert(plan.size(), row(MODE_ADD, 32'd9, 16'h1234));
        // fill the queue, pairs of equal times to check arrival order
        for (k = 0; k < DEPTH; k++)
            plan.insert(plan.size(), row(MODE_ADD, 32'(10 + k / 2),
                                         16'(16'h0100 + k)));
        // full queue drops this one
        plan.insert(plan.size(), row(MODE_ADD, 32'd10, 16'hBEEF));
        plan.insert(plan.size(), row(MODE_ADVANCE, 32'd20, 16'h0000));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_phase(0);
        foreach (plan[i])
            send_command(plan[i].mode, plan[i].tval, plan[i].id,
                         plan[i].typed, plan[i].has_word, plan[i].word);

        // random traffic, mostly near-future adds and small advances
        for (k = 0; k < RANDOM_WORDS; k++) begin
            set_phase(k * 4 / RANDOM_WORDS);
            pick = $urandom_range(0, 99);
            id   = 16'($urandom);
            if (pick < 42) begin
                m = MODE_ADD;
                t = clock_now + $urandom_range(0, 60);
            end else if (pick < 50) begin
                m = MODE_ADD;
                t = (clock_now > 50) ? clock_now - $urandom_range(1, 50)
                                     : clock_now + $urandom_range(0, 60);
            end else if (pick < 53) begin
                m = MODE_ADD;
                t = $urandom;
            end else if (pick < 63) begin
                m = MODE_REMOVE;
                t = (sched_count > 0) ? sched_time[$urandom_range(0, sched_count - 1)]
                                      : $urandom;
            end else if (pick < 67) begin
                m = MODE_REMOVE;
                t = $urandom;
            end else if (pick < 97) begin
                m = MODE_ADVANCE;
                t = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 45));
            end else begin
                m = MODE_UNUSED;
                t = $urandom;
            end
            send_command(m, t, id, 1'b0, 1'b0, '0);
        end

        // saturate the current time, then an entry exactly at the top
        send_command(MODE_ADVANCE, TIME_MAX, 16'h0000, 1'b0, 1'b0, '0);
        send_command(MODE_ADD, 32'd5, 16'h5A5A, 1'b0, 1'b0, '0);
        send_command(MODE_ADD, TIME_MAX, 16'hA5A5, 1'b0, 1'b0, '0);
        send_command(MODE_ADVANCE, 32'd1, 16'h0000, 1'b0, 1'b0, '0);
        s_axis_tvalid <= 1'b0;

        // drain, then watch for stray words
        while (due_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (due_q.size() != 0) begin
            $display("%0d expected words never arrived", due_q.size());
            err_count += due_q.size();
        end
        if (err_count == 0)
            $display("timed_event_queue_unit: match");
        else
            $display("timed_event_queue_unit: mismatch");
        $finish;
    end

endmodule
